// ----- hdl/eatc_pkg.sv -----
// Package for the event activity threshold counter.
// Holds field widths, function and register codes, and the accumulator types.
// No dependencies.
package eatc_pkg;

    // Number of pt thresholds and field widths
    localparam int NUM_THR     = 4;
    localparam int THR_W       = 16;
    localparam int COUNT_W     = 16;
    localparam int SUM_W       = 32;
    localparam int ETA_W       = 13;
    localparam int PHI_W       = 12;
    localparam int WIN_W       = 14;
    localparam int GAP_W       = 12;
    localparam int VETO_W      = 26;
    localparam int PT_W        = 16;
    localparam int FUNC_W      = 2;
    localparam int IDX_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 96;

    // Squared-distance widths: |deta| <= 8191, |dphi| <= 1608 after wrap
    localparam int ADE_W  = 13;
    localparam int ADP_W  = 11;
    localparam int SQE_W  = 26;
    localparam int SQP_W  = 22;
    localparam int DIST_W = 27;

    // Phi wrap constants, units of 1/512 rad
    localparam logic signed [13:0] PHI_HALF   = 14'sd1608;
    localparam logic signed [13:0] PHI_TWO_PI = 14'sd3217;

    // Accumulator memory: one row holds every threshold
    localparam int ACC_DEPTH  = 1;
    localparam int ACC_ADDR_W = 1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_START    = 2'd0,
        FUNC_PARTICLE = 2'd1,
        FUNC_JET      = 2'd2,
        FUNC_CLOSE    = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ETA_GAP      = 3'd0,
        CFG_VETO_SQ      = 3'd1,
        CFG_CHARGED_THR  = 3'd2,
        CFG_PARTICLE_THR = 3'd3,
        CFG_JET_THR      = 3'd4
    } t_cfg_reg;

    // One result; charged_count sits in the lowest bits
    typedef struct packed {
        logic [COUNT_W-1:0] jet_count;
        logic [SUM_W-1:0]   particle_sum;
        logic [SUM_W-1:0]   charged_sum;
        logic [COUNT_W-1:0] charged_count;
    } t_acc_row;

    typedef t_acc_row [NUM_THR-1:0] t_acc_bank;

    // Item fields carried down the pipeline
    typedef struct packed {
        t_func              func;
        logic [PT_W-1:0]    et;
        logic               charged;
        logic [NUM_THR-1:0] cmask;
        logic [NUM_THR-1:0] pmask;
        logic [NUM_THR-1:0] jmask;
    } t_item;

endpackage

// ----- hdl/eatc_ram.sv -----
// Generic single-clock RAM, one write port and one registered read port.
// Width and depth are parameters. No dependencies.
module eatc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic                                         i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // Write port, read port returns old data on a same-cycle write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/event_activity_threshold_counter_unit.sv -----
// Event activity threshold counter, top level.
// A close snapshots the row at stage 3; results leave one per cycle while m_axis_tready is high.
// Throughput: one item per cycle; a close holds the output for its NUM_THR results, and a
// second close stalls at the update stage until the previous results are drained.
// Accumulators live in a one-row RAM updated read-modify-write with forwarding of the last write.
// Reset (synchronous, active low) clears config, legs, window and the accumulator valid flag.
module event_activity_threshold_counter_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Item input
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // eta[12:0] phi[24:13] eta_second[37:25] phi_second[49:38] pt[65:50] et[81:66]
    // charged[82], zero pad above
    input  logic [eatc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // func[1:0]
    input  logic [eatc_pkg::FUNC_W-1:0]        s_axis_tuser,
    // Result output
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // charged_count[15:0] charged_et_sum[47:16] particle_et_sum[79:48] jet_count[95:80]
    output logic [eatc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // threshold_index[1:0]
    output logic [eatc_pkg::IDX_W-1:0]         m_axis_tuser,
    output logic                               m_axis_tlast,
    // Configuration write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [eatc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [eatc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // Configuration registers
    logic [eatc_pkg::GAP_W-1:0]             r_eta_gap;
    logic [eatc_pkg::VETO_W-1:0]            r_veto_sq;
    logic [eatc_pkg::NUM_THR*eatc_pkg::THR_W-1:0] r_cthr;
    logic [eatc_pkg::NUM_THR*eatc_pkg::THR_W-1:0] r_pthr;
    logic [eatc_pkg::NUM_THR*eatc_pkg::THR_W-1:0] r_jthr;

    // Event legs and eta window
    logic signed [eatc_pkg::ETA_W-1:0] r_leg1_eta, r_leg2_eta;
    logic signed [eatc_pkg::PHI_W-1:0] r_leg1_phi, r_leg2_phi;
    logic signed [eatc_pkg::WIN_W-1:0] r_win_lo, r_win_hi;

    // Pipeline registers
    logic                             r_s1_vld, r_s2_vld, r_s3_vld;
    eatc_pkg::t_item                  r_s1_item, r_s2_item, r_s3_item;
    logic                             r_s1_win, r_s2_win, r_s3_keep;
    logic [eatc_pkg::ADE_W-1:0]       r_s1_ade1, r_s1_ade2;
    logic [eatc_pkg::ADP_W-1:0]       r_s1_adp1, r_s1_adp2;
    logic [eatc_pkg::SQE_W-1:0]       r_s2_sqe1, r_s2_sqe2;
    logic [eatc_pkg::SQP_W-1:0]       r_s2_sqp1, r_s2_sqp2;

    // Accumulator memory control
    logic                             r_acc_vld;
    logic                             r_fwd_vld;
    eatc_pkg::t_acc_bank              r_fwd_row;
    eatc_pkg::t_acc_bank              ram_rdata;

    // Output snapshot
    eatc_pkg::t_acc_bank              r_snap;
    logic                             r_busy, n_busy;
    logic [eatc_pkg::IDX_W-1:0]       r_idx, n_idx;

    // Input decode
    eatc_pkg::t_func                   in_func;
    logic signed [eatc_pkg::ETA_W-1:0] in_eta, in_eta2;
    logic signed [eatc_pkg::PHI_W-1:0] in_phi, in_phi2;
    logic [eatc_pkg::PT_W-1:0]         in_pt, in_et;
    logic                              in_chg;

    logic                              en, acc, out_take, last_take;
    logic signed [eatc_pkg::ETA_W-1:0] leg_lo, leg_hi;
    logic signed [eatc_pkg::WIN_W-1:0] eta_x, n_win_lo, n_win_hi;
    eatc_pkg::t_item                   s0_item;
    logic [eatc_pkg::DIST_W-1:0]       dist1, dist2;
    logic                              s2_keep;
    eatc_pkg::t_acc_bank               cur_row, upd_row, new_row;
    logic                              wr, ld;

    // |a - b| of two etas, 14-bit difference
    function automatic logic [eatc_pkg::ADE_W-1:0] eta_abs_diff(
        input logic signed [eatc_pkg::ETA_W-1:0] a,
        input logic signed [eatc_pkg::ETA_W-1:0] b
    );
        logic signed [eatc_pkg::WIN_W-1:0] d;
        d = $signed({a[eatc_pkg::ETA_W-1], a}) - $signed({b[eatc_pkg::ETA_W-1], b});
        return d[eatc_pkg::WIN_W-1] ? eatc_pkg::ADE_W'(-d) : eatc_pkg::ADE_W'(d);
    endfunction

    // |a - b| of two phis after wrapping into [-1608, 1608]; one step suffices
    function automatic logic [eatc_pkg::ADP_W-1:0] phi_abs_diff(
        input logic signed [eatc_pkg::PHI_W-1:0] a,
        input logic signed [eatc_pkg::PHI_W-1:0] b
    );
        logic signed [13:0] d;
        logic signed [13:0] w;
        d = $signed({{2{a[eatc_pkg::PHI_W-1]}}, a}) - $signed({{2{b[eatc_pkg::PHI_W-1]}}, b});
        if (d > eatc_pkg::PHI_HALF) begin
            w = d - eatc_pkg::PHI_TWO_PI;
        end else if (d < -eatc_pkg::PHI_HALF) begin
            w = d + eatc_pkg::PHI_TWO_PI;
        end else begin
            w = d;
        end
        return w[13] ? eatc_pkg::ADP_W'(-w) : eatc_pkg::ADP_W'(w);
    endfunction

    // Field unpacking
    assign in_func = eatc_pkg::t_func'(s_axis_tuser);
    assign in_eta  = s_axis_tdata[12:0];
    assign in_phi  = s_axis_tdata[24:13];
    assign in_eta2 = s_axis_tdata[37:25];
    assign in_phi2 = s_axis_tdata[49:38];
    assign in_pt   = s_axis_tdata[65:50];
    assign in_et   = s_axis_tdata[81:66];
    assign in_chg  = s_axis_tdata[82];

    // Handshake: whole pipeline holds only while a close waits for the output
    assign out_take  = m_axis_tvalid && m_axis_tready;
    assign last_take = out_take && (r_idx == eatc_pkg::IDX_W'(eatc_pkg::NUM_THR - 1));
    assign en = !(r_s3_vld && (r_s3_item.func == eatc_pkg::FUNC_CLOSE) && r_busy && !last_take);
    assign s_axis_tready = en;
    assign acc = s_axis_tvalid && en;
    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta_gap <= '0;
            r_veto_sq <= '0;
            r_cthr    <= '0;
            r_pthr    <= '0;
            r_jthr    <= '0;
        end else if (i_cfg_valid) begin
            case (eatc_pkg::t_cfg_reg'(i_cfg_index))
                eatc_pkg::CFG_ETA_GAP:      r_eta_gap <= i_cfg_data[eatc_pkg::GAP_W-1:0];
                eatc_pkg::CFG_VETO_SQ:      r_veto_sq <= i_cfg_data[eatc_pkg::VETO_W-1:0];
                eatc_pkg::CFG_CHARGED_THR:  r_cthr <= i_cfg_data;
                eatc_pkg::CFG_PARTICLE_THR: r_pthr <= i_cfg_data;
                eatc_pkg::CFG_JET_THR:      r_jthr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 0: window from new legs, window test and threshold compares
    always_comb begin
        leg_lo   = (in_eta < in_eta2) ? in_eta : in_eta2;
        leg_hi   = (in_eta < in_eta2) ? in_eta2 : in_eta;
        n_win_lo = $signed({leg_lo[eatc_pkg::ETA_W-1], leg_lo}) - $signed({2'b00, r_eta_gap});
        n_win_hi = $signed({leg_hi[eatc_pkg::ETA_W-1], leg_hi}) + $signed({2'b00, r_eta_gap});
        eta_x    = $signed({in_eta[eatc_pkg::ETA_W-1], in_eta});
        s0_item.func    = in_func;
        s0_item.et      = in_et;
        s0_item.charged = in_chg;
        for (int i = 0; i < eatc_pkg::NUM_THR; i++) begin
            s0_item.cmask[i] = in_pt > r_cthr[i*eatc_pkg::THR_W +: eatc_pkg::THR_W];
            s0_item.pmask[i] = in_pt > r_pthr[i*eatc_pkg::THR_W +: eatc_pkg::THR_W];
            s0_item.jmask[i] = in_pt > r_jthr[i*eatc_pkg::THR_W +: eatc_pkg::THR_W];
        end
    end

    // Legs and window load on a start item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leg1_eta <= '0;
            r_leg1_phi <= '0;
            r_leg2_eta <= '0;
            r_leg2_phi <= '0;
            r_win_lo   <= '0;
            r_win_hi   <= '0;
        end else if (acc && (in_func == eatc_pkg::FUNC_START)) begin
            r_leg1_eta <= in_eta;
            r_leg1_phi <= in_phi;
            r_leg2_eta <= in_eta2;
            r_leg2_phi <= in_phi2;
            r_win_lo   <= n_win_lo;
            r_win_hi   <= n_win_hi;
        end
    end

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= acc;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    // Distance terms, squares, then veto decision
    assign dist1   = eatc_pkg::DIST_W'(r_s2_sqe1) + eatc_pkg::DIST_W'(r_s2_sqp1);
    assign dist2   = eatc_pkg::DIST_W'(r_s2_sqe2) + eatc_pkg::DIST_W'(r_s2_sqp2);
    assign s2_keep = r_s2_win && (dist1 > eatc_pkg::DIST_W'(r_veto_sq))
                     && (dist2 > eatc_pkg::DIST_W'(r_veto_sq));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_item <= s0_item;
            r_s1_win  <= (eta_x > r_win_lo) && (eta_x < r_win_hi);
            r_s1_ade1 <= eta_abs_diff(in_eta, r_leg1_eta);
            r_s1_ade2 <= eta_abs_diff(in_eta, r_leg2_eta);
            r_s1_adp1 <= phi_abs_diff(in_phi, r_leg1_phi);
            r_s1_adp2 <= phi_abs_diff(in_phi, r_leg2_phi);
            r_s2_item <= r_s1_item;
            r_s2_win  <= r_s1_win;
            r_s2_sqe1 <= eatc_pkg::SQE_W'(r_s1_ade1) * eatc_pkg::SQE_W'(r_s1_ade1);
            r_s2_sqe2 <= eatc_pkg::SQE_W'(r_s1_ade2) * eatc_pkg::SQE_W'(r_s1_ade2);
            r_s2_sqp1 <= eatc_pkg::SQP_W'(r_s1_adp1) * eatc_pkg::SQP_W'(r_s1_adp1);
            r_s2_sqp2 <= eatc_pkg::SQP_W'(r_s1_adp2) * eatc_pkg::SQP_W'(r_s1_adp2);
            r_s3_item <= r_s2_item;
            r_s3_keep <= s2_keep;
        end
    end

    // Accumulator memory, read every cycle
    eatc_ram #(
        .WIDTH ($bits(eatc_pkg::t_acc_bank)),
        .DEPTH (eatc_pkg::ACC_DEPTH)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (wr),
        .i_waddr ({eatc_pkg::ACC_ADDR_W{1'b0}}),
        .i_wdata (new_row),
        .i_re    (1'b1),
        .i_raddr ({eatc_pkg::ACC_ADDR_W{1'b0}}),
        .o_rdata (ram_rdata)
    );

    // Stage 3: current row (forward last write, unwritten row reads zero), then update
    always_comb begin
        logic [eatc_pkg::SUM_W:0] s;
        s = '0;
        if (r_fwd_vld) begin
            cur_row = r_fwd_row;
        end else if (r_acc_vld) begin
            cur_row = ram_rdata;
        end else begin
            cur_row = '0;
        end
        upd_row = cur_row;
        for (int i = 0; i < eatc_pkg::NUM_THR; i++) begin
            if (r_s3_item.func == eatc_pkg::FUNC_PARTICLE) begin
                if (r_s3_item.charged && r_s3_item.cmask[i]) begin
                    if (cur_row[i].charged_count != '1) begin
                        upd_row[i].charged_count = cur_row[i].charged_count + 1'b1;
                    end
                    s = {1'b0, cur_row[i].charged_sum} + (eatc_pkg::SUM_W + 1)'(r_s3_item.et);
                    upd_row[i].charged_sum = s[eatc_pkg::SUM_W] ? '1 : s[eatc_pkg::SUM_W-1:0];
                end
                if (r_s3_item.pmask[i]) begin
                    s = {1'b0, cur_row[i].particle_sum} + (eatc_pkg::SUM_W + 1)'(r_s3_item.et);
                    upd_row[i].particle_sum = s[eatc_pkg::SUM_W] ? '1 : s[eatc_pkg::SUM_W-1:0];
                end
            end else if (r_s3_item.func == eatc_pkg::FUNC_JET) begin
                if (r_s3_item.jmask[i] && (cur_row[i].jet_count != '1)) begin
                    upd_row[i].jet_count = cur_row[i].jet_count + 1'b1;
                end
            end
        end
        if (r_s3_item.func == eatc_pkg::FUNC_START) begin
            new_row = '0;
        end else if (r_s3_keep) begin
            new_row = upd_row;
        end else begin
            new_row = cur_row;
        end
        wr = r_s3_vld && en && (r_s3_item.func != eatc_pkg::FUNC_CLOSE);
        ld = r_s3_vld && en && (r_s3_item.func == eatc_pkg::FUNC_CLOSE);
    end

    // Write tracking and forwarding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= 1'b0;
            r_fwd_vld <= 1'b0;
        end else begin
            r_acc_vld <= r_acc_vld || wr;
            r_fwd_vld <= wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_fwd_row <= new_row;
        end
        if (ld) begin
            r_snap <= cur_row;
        end
    end

    // Result sequencer over the snapshot
    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (ld) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (last_take) begin
            n_busy = 1'b0;
        end else if (out_take) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    assign m_axis_tvalid = r_busy;
    assign m_axis_tdata  = r_snap[r_idx];
    assign m_axis_tuser  = r_idx;
    assign m_axis_tlast  = (r_idx == eatc_pkg::IDX_W'(eatc_pkg::NUM_THR - 1));

endmodule
